>>> rtl/sha1mh_pkg.sv
// ----------------------------------------------------------------------------
// sha1mh_pkg
// Shared types and constants of the SHA-1 message hasher: word types,
// initial chaining values, round constants and schedule control.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FillW      = 6;
  localparam int unsigned LenW       = 64;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned RndW       = 7;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned BytesPerBl = 64;

  typedef logic [WordW-1:0] word_t;

  // working variables of the compression function
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  // control of the message schedule window
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [ByteW-1:0] data;
  } sched_ctrl_t;

  localparam word_t HInit [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [RndW-1:0] RndPh1  = RndW'(20);
  localparam logic [RndW-1:0] RndPh2  = RndW'(40);
  localparam logic [RndW-1:0] RndPh3  = RndW'(60);
  localparam logic [RndW-1:0] RndLast = RndW'(NumRounds - 1);

  localparam logic [FillW-1:0] FillLast   = FillW'(BytesPerBl - 1);
  localparam logic [FillW-1:0] FillLenPos = FillW'(LenPos);

  localparam logic [ByteW-1:0] PadMark = 8'h80;
  localparam logic [IdxW-1:0]  IdxLast = IdxW'(NumWords - 1);

endpackage

>>> rtl/sha1mh_if.sv
// ----------------------------------------------------------------------------
// sha1mh_if
// Valid/ready channels of the SHA-1 message hasher: byte input and
// digest word output.
// ----------------------------------------------------------------------------
interface sha1mh_in_if;
  logic                          valid;
  logic                          ready;
  logic [sha1mh_pkg::ByteW-1:0]  data_byte;
  logic                          byte_present;
  logic                          end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1mh_out_if;
  logic                         valid;
  logic                         ready;
  sha1mh_pkg::word_t            digest_word;
  logic [sha1mh_pkg::IdxW-1:0]  word_index;
  logic                         last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> rtl/sha1_message_hasher_top.sv
// Input: message bytes are taken only while idle; the byte that fills a block
//   starts 80 rounds on the shared round unit and one chain add, and input stalls.
// End of message: 9 to 72 padding bytes at one a cycle, each padded block hashed
//   the same way, then five digest words, one a cycle while the sink is ready.
// Over full blocks the byte rate is set by the round unit.
// Reset: asynchronous, restores the initial chain and clears count and length.
// ----------------------------------------------------------------------------
// sha1_message_hasher_top
// SHA-1 over a byte stream: gathers 64-byte blocks, pads at end of message
// and delivers the digest as five 32-bit words.
// ----------------------------------------------------------------------------
module sha1_message_hasher_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha1mh_in_if.sink          in_i,
  sha1mh_out_if.source       out_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e                             state_q, state_d;
  logic [sha1mh_pkg::FillW-1:0]       fill_q;
  logic [sha1mh_pkg::LenW-1:0]        bits_q;
  logic [sha1mh_pkg::RndW-1:0]        rnd_q;
  logic [sha1mh_pkg::IdxW-1:0]        widx_q;
  logic                               pad_act_q, pad_act_d;
  logic                               pad_first_q, pad_first_d;
  logic                               pad_last_q, pad_last_d;
  logic                               done_q, done_d;
  sha1mh_pkg::word_t                  h_q [sha1mh_pkg::NumWords];
  sha1mh_pkg::work_t                  work_q;
  sha1mh_pkg::work_t                  work_nxt;
  sha1mh_pkg::word_t                  w_cur;
  sha1mh_pkg::sched_ctrl_t            sched_ctrl;
  sha1mh_pkg::word_t                  out_word;

  logic                         in_acc;
  logic                         out_acc;
  logic                         wr_en;
  logic [sha1mh_pkg::ByteW-1:0] wr_byte;
  logic [sha1mh_pkg::ByteW-1:0] len_byte;
  logic                         blk_full;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  assign in_i.ready = (state_q == ST_IDLE);

  // big-endian length byte for positions 56..63
  assign len_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];

  // byte written into the block: message byte or padding
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = in_i.data_byte;
    if (state_q == ST_IDLE) begin
      wr_en = in_acc & in_i.byte_present;
    end else if (state_q == ST_PAD) begin
      wr_en = 1'b1;
      if (pad_first_q) begin
        wr_byte = sha1mh_pkg::PadMark;
      end else if (pad_last_q && (fill_q >= sha1mh_pkg::FillLenPos)) begin
        wr_byte = len_byte;
      end else begin
        wr_byte = '0;
      end
    end
  end

  assign blk_full = wr_en && (fill_q == sha1mh_pkg::FillLast);

  assign sched_ctrl.load  = wr_en;
  assign sched_ctrl.shift = (state_q == ST_ROUND);
  assign sched_ctrl.data  = wr_byte;

  sha1mh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w_cur)
  );

  sha1mh_round u_round (
    .cur_i   (work_q),
    .w_i     (w_cur),
    .round_i (rnd_q),
    .nxt_o   (work_nxt)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    pad_act_d   = pad_act_q;
    pad_first_d = pad_first_q;
    pad_last_d  = pad_last_q;
    done_d      = done_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.end_of_message) begin
          pad_act_d   = 1'b1;
          pad_first_d = 1'b1;
          pad_last_d  = 1'b0;
          state_d     = ST_PAD;
        end
        if (blk_full) begin
          state_d = ST_ROUND;
        end
      end
      ST_PAD: begin
        pad_first_d = 1'b0;
        if (pad_first_q) begin
          pad_last_d = (fill_q < sha1mh_pkg::FillLenPos);
        end
        if (blk_full) begin
          done_d     = pad_last_q;
          pad_last_d = 1'b1;
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == sha1mh_pkg::RndLast) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (done_q) begin
          state_d = ST_OUT;
        end else if (pad_act_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && (widx_q == sha1mh_pkg::IdxLast)) begin
          pad_act_d = 1'b0;
          done_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bits_q      <= '0;
      rnd_q       <= '0;
      widx_q      <= '0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      pad_last_q  <= 1'b0;
      done_q      <= 1'b0;
      h_q         <= sha1mh_pkg::HInit;
    end else begin
      state_q     <= state_d;
      pad_act_q   <= pad_act_d;
      pad_first_q <= pad_first_d;
      pad_last_q  <= pad_last_d;
      done_q      <= done_d;
      if (wr_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (in_acc && in_i.byte_present) begin
        bits_q <= bits_q + sha1mh_pkg::LenW'(8);
      end
      if (state_q == ST_ROUND) begin
        rnd_q <= (rnd_q == sha1mh_pkg::RndLast) ? '0 : rnd_q + 1'b1;
      end
      if (state_q == ST_ADD) begin
        h_q[0] <= h_q[0] + work_q.a;
        h_q[1] <= h_q[1] + work_q.b;
        h_q[2] <= h_q[2] + work_q.c;
        h_q[3] <= h_q[3] + work_q.d;
        h_q[4] <= h_q[4] + work_q.e;
      end
      if (out_acc) begin
        if (widx_q == sha1mh_pkg::IdxLast) begin
          widx_q <= '0;
          fill_q <= '0;
          bits_q <= '0;
          h_q    <= sha1mh_pkg::HInit;
        end else begin
          widx_q <= widx_q + 1'b1;
        end
      end
    end
  end

  // working variables: load from chain at block start, then one round a cycle
  always_ff @(posedge clk_i) begin
    if (blk_full) begin
      work_q <= '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
    end else if (state_q == ST_ROUND) begin
      work_q <= work_nxt;
    end
  end

  // digest word select
  always_comb begin
    unique case (widx_q)
      3'd0:    out_word = h_q[0];
      3'd1:    out_word = h_q[1];
      3'd2:    out_word = h_q[2];
      3'd3:    out_word = h_q[3];
      3'd4:    out_word = h_q[4];
      default: out_word = '0;
    endcase
  end

  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.digest_word = out_word;
  assign out_o.word_index  = widx_q;
  assign out_o.last_word   = (widx_q == sha1mh_pkg::IdxLast);

endmodule

>>> rtl/sha1mh_sched.sv
// ----------------------------------------------------------------------------
// sha1mh_sched
// Sixteen-word message window. Bytes shift in while a block is gathered;
// during the rounds the window shifts one word a cycle and appends the
// next expanded schedule word.
// ----------------------------------------------------------------------------
module sha1mh_sched (
  input  logic                    clk_i,
  input  sha1mh_pkg::sched_ctrl_t ctrl_i,
  output sha1mh_pkg::word_t       w_o
);

  localparam int unsigned WinW = 16 * sha1mh_pkg::WordW;

  // oldest word sits in the top bits
  logic [WinW-1:0]   win_q;
  sha1mh_pkg::word_t w_new;
  sha1mh_pkg::word_t w_mix;

  // w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
  assign w_mix = win_q[2*32 +: 32] ^ win_q[7*32 +: 32] ^
                 win_q[13*32 +: 32] ^ win_q[15*32 +: 32];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w_o   = win_q[15*32 +: 32];

  // window update
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      win_q <= {win_q[WinW-sha1mh_pkg::ByteW-1:0], ctrl_i.data};
    end else if (ctrl_i.shift) begin
      win_q <= {win_q[WinW-sha1mh_pkg::WordW-1:0], w_new};
    end
  end

endmodule

>>> rtl/sha1mh_round.sv
// ----------------------------------------------------------------------------
// sha1mh_round
// One SHA-1 round: selects the boolean function and constant by round
// number and produces the next working variables.
// ----------------------------------------------------------------------------
module sha1mh_round (
  input  sha1mh_pkg::work_t                 cur_i,
  input  sha1mh_pkg::word_t                 w_i,
  input  logic [sha1mh_pkg::RndW-1:0]       round_i,
  output sha1mh_pkg::work_t                 nxt_o
);

  sha1mh_pkg::word_t f;
  sha1mh_pkg::word_t k;
  sha1mh_pkg::word_t t;

  // function and constant per group of twenty rounds
  always_comb begin
    if (round_i < sha1mh_pkg::RndPh1) begin
      f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      k = sha1mh_pkg::K0;
    end else if (round_i < sha1mh_pkg::RndPh2) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = sha1mh_pkg::K1;
    end else if (round_i < sha1mh_pkg::RndPh3) begin
      f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
      k = sha1mh_pkg::K2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = sha1mh_pkg::K3;
    end
  end

  // temp sum and rotation of the working variables
  assign t = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + k + w_i;

  assign nxt_o.a = t;
  assign nxt_o.b = cur_i.a;
  assign nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
  assign nxt_o.d = cur_i.c;
  assign nxt_o.e = cur_i.d;

endmodule

>>> rtl/sha1mh_checker.sv
// ----------------------------------------------------------------------------
// sha1mh_checker
// Port-level checks of the SHA-1 message hasher: digest word ordering,
// input blocking while the digest is delivered, output transaction hold.
// ----------------------------------------------------------------------------
module sha1mh_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input sha1mh_pkg::word_t            out_word_i,
  input logic [sha1mh_pkg::IdxW-1:0]  out_index_i,
  input logic                         out_last_i
);

  // a stalled output transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) &&
    $stable(out_index_i) && $stable(out_last_i))
    else $error("output transaction changed while stalled");

  // no input transaction is taken while the digest is delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while digest pending");

  // digest words follow one another in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
    out_valid_i && (out_index_i == $past(out_index_i) + 3'd1))
    else $error("digest word out of order");

  // the last word closes the digest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("output continued after last digest word");

endmodule

bind sha1_message_hasher_top sha1mh_checker u_sha1mh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.digest_word),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.last_word)
);
